@@ rtl/core/olh_pkg.sv @@
// ----------------------------------------------------------------------------
// olh_pkg
// shared types, codes and sizes of the occupancy alarm with hysteresis
// ----------------------------------------------------------------------------
package olh_pkg;

    localparam int ZONES      = 16;
    localparam int ZONE_W     = 4;
    localparam int ZIDX_W     = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int CNT_W      = 16;
    localparam int PERMILLE_W = 12;
    localparam int REL_W      = 10;
    localparam int EVENT_W    = 3;
    localparam int LEVEL_W    = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [REL_W-1:0] RELEASE_RESET = REL_W'(900);

    // register index of the release band
    localparam logic [APB_ADDR_W-3:0] REG_RELEASE = '0;

    // stored incident severity, also used as grade of a count
    typedef enum logic [1:0] {
        SEV_NONE = 2'd0,
        SEV_WARN = 2'd1,
        SEV_CRIT = 2'd2
    } sev_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_UNKNOWN  = 3'd0,
        EV_QUIET    = 3'd1,
        EV_OPEN     = 3'd2,
        EV_ESCALATE = 3'd3,
        EV_RESOLVE  = 3'd4,
        EV_HOLD     = 3'd5
    } event_t;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_UNKNOWN = 2'd0,
        LVL_CLEAR   = 2'd1,
        LVL_WARN    = 2'd2,
        LVL_CRIT    = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_START,
        TOP_WAIT,
        TOP_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        RU_IDLE,
        RU_REL,
        RU_CAP,
        RU_CMP
    } ru_state_t;

    typedef struct packed {
        logic                  start;
        logic [CNT_W-1:0]      chosen;
        logic [CNT_W-1:0]      capacity;
        logic [PERMILLE_W-1:0] warn;
        logic [PERMILLE_W-1:0] crit;
        logic [REL_W-1:0]      release_pm;
    } ratio_req_t;

    typedef struct packed {
        logic done;
        sev_t grade;
        logic below;
    } ratio_res_t;

    typedef struct packed {
        event_t event_res;
        level_t level;
    } sev_dec_t;

endpackage

@@ rtl/core/olh_select.sv @@
// ----------------------------------------------------------------------------
// olh_select
// picks the worst of up to three optional person counts
// ----------------------------------------------------------------------------
module olh_select (
    input  logic                      current_valid,
    input  logic [olh_pkg::CNT_W-1:0] cur_count,
    input  logic                      median_valid,
    input  logic [olh_pkg::CNT_W-1:0] median_count,
    input  logic                      pred_valid,
    input  logic [olh_pkg::CNT_W-1:0] pred_count,
    output logic                      have,
    output logic [olh_pkg::CNT_W-1:0] chosen,
    output logic                      from_pred
);

    logic                      have_cm;
    logic [olh_pkg::CNT_W-1:0] chosen_cm;

    always_comb
    begin
        have_cm   = current_valid;
        chosen_cm = current_valid ? cur_count : '0;
        // median only wins when strictly greater
        if (median_valid && (!have_cm || median_count > chosen_cm))
        begin
            chosen_cm = median_count;
            have_cm   = 1'b1;
        end
        have      = have_cm;
        chosen    = chosen_cm;
        from_pred = 1'b0;
        // prediction wins ties
        if (pred_valid && (!have_cm || pred_count >= chosen_cm))
        begin
            chosen    = pred_count;
            have      = 1'b1;
            from_pred = 1'b1;
        end
    end

endmodule

@@ rtl/core/olh_ratio_unit.sv @@
// ----------------------------------------------------------------------------
// olh_ratio_unit
// bit-serial threshold products and ratio grading
// ----------------------------------------------------------------------------
module olh_ratio_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  olh_pkg::ratio_req_t req,
    output olh_pkg::ratio_res_t res
);

    localparam int K_W  = olh_pkg::CNT_W + 10;
    localparam int M_W  = olh_pkg::CNT_W + 20;
    localparam int WR_W = olh_pkg::PERMILLE_W + olh_pkg::REL_W;
    localparam int PC_W = olh_pkg::PERMILLE_W + olh_pkg::CNT_W;
    localparam int PR_W = WR_W + olh_pkg::CNT_W;
    localparam int CT_W = $clog2(olh_pkg::CNT_W);

    // x * 1000 as (x << 10) - (x << 4) - (x << 3)
    function automatic logic [M_W-1:0] times_1000(input logic [M_W-1:0] x);
        times_1000 = (x << 10) - (x << 4) - (x << 3);
    endfunction

    olh_pkg::ru_state_t state_reg, state_next;
    logic [CT_W-1:0]    cnt_reg, cnt_next;
    logic               done_reg, done_next;
    olh_pkg::sev_t      grade_reg, grade_next;
    logic               below_reg, below_next;

    logic [olh_pkg::PERMILLE_W-1:0] warn_reg, warn_next;
    logic [olh_pkg::PERMILLE_W-1:0] crit_reg, crit_next;
    logic [olh_pkg::REL_W-1:0]      rel_sr_reg, rel_sr_next;
    logic [olh_pkg::CNT_W-1:0]      cap_sr_reg, cap_sr_next;
    logic [K_W-1:0]                 scaled_k_reg, scaled_k_next;
    logic [M_W-1:0]                 scaled_m_reg, scaled_m_next;
    logic [WR_W-1:0]                wr_reg, wr_next;
    logic [PC_W-1:0]                acc_c_reg, acc_c_next;
    logic [PC_W-1:0]                acc_w_reg, acc_w_next;
    logic [PR_W-1:0]                acc_r_reg, acc_r_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        grade_next    = grade_reg;
        below_next    = below_reg;
        warn_next     = warn_reg;
        crit_next     = crit_reg;
        rel_sr_next   = rel_sr_reg;
        cap_sr_next   = cap_sr_reg;
        scaled_k_next = scaled_k_reg;
        scaled_m_next = scaled_m_reg;
        wr_next       = wr_reg;
        acc_c_next    = acc_c_reg;
        acc_w_next    = acc_w_reg;
        acc_r_next    = acc_r_reg;

        unique case (state_reg)
            olh_pkg::RU_IDLE:
            begin
                if (req.start)
                begin
                    warn_next     = req.warn;
                    crit_next     = req.crit;
                    rel_sr_next   = req.release_pm;
                    cap_sr_next   = req.capacity;
                    scaled_k_next = K_W'(times_1000(M_W'(req.chosen)));
                    wr_next       = '0;
                    acc_c_next    = '0;
                    acc_w_next    = '0;
                    acc_r_next    = '0;
                    cnt_next      = CT_W'(olh_pkg::REL_W - 1);
                    state_next    = olh_pkg::RU_REL;
                end
            end
            olh_pkg::RU_REL:
            begin
                // warn * release, msb first
                wr_next = {wr_reg[WR_W-2:0], 1'b0}
                        + (rel_sr_reg[olh_pkg::REL_W-1] ? WR_W'(warn_reg) : '0);
                rel_sr_next   = {rel_sr_reg[olh_pkg::REL_W-2:0], 1'b0};
                scaled_m_next = times_1000(M_W'(scaled_k_reg));
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CT_W'(olh_pkg::CNT_W - 1);
                    state_next = olh_pkg::RU_CAP;
                end
            end
            olh_pkg::RU_CAP:
            begin
                // three products with capacity, one capacity bit per cycle
                acc_c_next = {acc_c_reg[PC_W-2:0], 1'b0}
                           + (cap_sr_reg[olh_pkg::CNT_W-1] ? PC_W'(crit_reg) : '0);
                acc_w_next = {acc_w_reg[PC_W-2:0], 1'b0}
                           + (cap_sr_reg[olh_pkg::CNT_W-1] ? PC_W'(warn_reg) : '0);
                acc_r_next = {acc_r_reg[PR_W-2:0], 1'b0}
                           + (cap_sr_reg[olh_pkg::CNT_W-1] ? PR_W'(wr_reg) : '0);
                cap_sr_next = {cap_sr_reg[olh_pkg::CNT_W-2:0], 1'b0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = olh_pkg::RU_CMP;
                end
            end
            olh_pkg::RU_CMP:
            begin
                priority if (PC_W'(scaled_k_reg) >= acc_c_reg)
                begin
                    grade_next = olh_pkg::SEV_CRIT;
                end
                else if (PC_W'(scaled_k_reg) >= acc_w_reg)
                begin
                    grade_next = olh_pkg::SEV_WARN;
                end
                else
                begin
                    grade_next = olh_pkg::SEV_NONE;
                end
                below_next = PR_W'(scaled_m_reg) < acc_r_reg;
                done_next  = 1'b1;
                state_next = olh_pkg::RU_IDLE;
            end
            default:
            begin
                state_next = olh_pkg::RU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olh_pkg::RU_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grade_reg    <= grade_next;
        below_reg    <= below_next;
        warn_reg     <= warn_next;
        crit_reg     <= crit_next;
        rel_sr_reg   <= rel_sr_next;
        cap_sr_reg   <= cap_sr_next;
        scaled_k_reg <= scaled_k_next;
        scaled_m_reg <= scaled_m_next;
        wr_reg       <= wr_next;
        acc_c_reg    <= acc_c_next;
        acc_w_reg    <= acc_w_next;
        acc_r_reg    <= acc_r_next;
    end

    assign res.done  = done_reg;
    assign res.grade = grade_reg;
    assign res.below = below_reg;

endmodule

@@ rtl/core/olh_sev_store.sv @@
// ----------------------------------------------------------------------------
// olh_sev_store
// per-zone open incident severity and its transition rules
// ----------------------------------------------------------------------------
module olh_sev_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [olh_pkg::ZONE_W-1:0] zone,
    input  olh_pkg::sev_t              grade,
    input  logic                       below,
    input  logic                       commit,
    output olh_pkg::sev_dec_t          dec
);

    olh_pkg::sev_t sev_reg  [olh_pkg::ZONES];
    olh_pkg::sev_t sev_next [olh_pkg::ZONES];

    logic [olh_pkg::ZIDX_W-1:0] idx;
    olh_pkg::sev_t              open_sev;
    olh_pkg::sev_t              new_sev;

    assign idx      = olh_pkg::ZIDX_W'(zone % olh_pkg::ZONES);
    assign open_sev = sev_reg[idx];

    always_comb
    begin
        new_sev = open_sev;
        priority if (open_sev == olh_pkg::SEV_NONE)
        begin
            if (grade == olh_pkg::SEV_NONE)
            begin
                dec.event_res = olh_pkg::EV_QUIET;
                dec.level     = olh_pkg::LVL_CLEAR;
            end
            else
            begin
                new_sev       = grade;
                dec.event_res = olh_pkg::EV_OPEN;
                dec.level     = (grade == olh_pkg::SEV_CRIT) ? olh_pkg::LVL_CRIT
                                                             : olh_pkg::LVL_WARN;
            end
        end
        // escalation is checked before release
        else if (grade == olh_pkg::SEV_CRIT && open_sev == olh_pkg::SEV_WARN)
        begin
            new_sev       = olh_pkg::SEV_CRIT;
            dec.event_res = olh_pkg::EV_ESCALATE;
            dec.level     = olh_pkg::LVL_CRIT;
        end
        else if (below)
        begin
            new_sev       = olh_pkg::SEV_NONE;
            dec.event_res = olh_pkg::EV_RESOLVE;
            dec.level     = olh_pkg::LVL_CLEAR;
        end
        else
        begin
            // downgrades are ignored, level follows the stored severity
            dec.event_res = olh_pkg::EV_HOLD;
            dec.level     = (open_sev == olh_pkg::SEV_CRIT) ? olh_pkg::LVL_CRIT
                                                            : olh_pkg::LVL_WARN;
        end
    end

    always_comb
    begin
        sev_next = sev_reg;
        if (commit)
        begin
            sev_next[idx] = new_sev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < olh_pkg::ZONES; i++)
            begin
                sev_reg[i] <= olh_pkg::SEV_NONE;
            end
        end
        else
        begin
            sev_reg <= sev_next;
        end
    end

endmodule

@@ rtl/core/occupancy_alarm_hysteresis.sv @@
// ----------------------------------------------------------------------------
// occupancy_alarm_hysteresis
// per-zone occupancy alarm with hysteresis over three optional counts
// ----------------------------------------------------------------------------
// flow: one word at a time; a zone with unknown state (no thresholds, zero
//   capacity, no count) skips the ratio unit, which walks the release
//   register (10 bits) and then the capacity (16 bits) one bit a cycle; a
//   stalled result word holds the next one back
// reset: all zones hold no open incident, release_permille is 900
// ----------------------------------------------------------------------------
module occupancy_alarm_hysteresis (
    input  logic                               clk,
    input  logic                               rst_n,

    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [olh_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [olh_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [olh_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,

    // input words
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [olh_pkg::ZONE_W-1:0]         zone,
    input  logic                               thresholds_present,
    input  logic [olh_pkg::CNT_W-1:0]          capacity,
    input  logic [olh_pkg::PERMILLE_W-1:0]     warn_permille,
    input  logic [olh_pkg::PERMILLE_W-1:0]     crit_permille,
    input  logic                               current_valid,
    input  logic [olh_pkg::CNT_W-1:0]          cur_count,
    input  logic                               median_valid,
    input  logic [olh_pkg::CNT_W-1:0]          median_count,
    input  logic                               pred_valid,
    input  logic [olh_pkg::CNT_W-1:0]          pred_count,

    // result words
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [olh_pkg::ZONE_W-1:0]         zone_out,
    output logic [olh_pkg::EVENT_W-1:0]        event_res,
    output logic [olh_pkg::LEVEL_W-1:0]        level,
    output logic [olh_pkg::CNT_W-1:0]          chosen_count,
    output logic                               from_prediction
);

    // control state
    olh_pkg::top_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [olh_pkg::REL_W-1:0] release_reg, release_next;

    // captured word
    logic [olh_pkg::ZONE_W-1:0]     zone_reg, zone_next;
    logic                           known_reg, known_next;
    logic [olh_pkg::CNT_W-1:0]      chosen_reg, chosen_next;
    logic                           from_pred_reg, from_pred_next;
    logic [olh_pkg::CNT_W-1:0]      cap_reg, cap_next;
    logic [olh_pkg::PERMILLE_W-1:0] warn_reg, warn_next;
    logic [olh_pkg::PERMILLE_W-1:0] crit_reg, crit_next;
    olh_pkg::sev_t                  grade_reg, grade_next;
    logic                           below_reg, below_next;

    // output word
    logic [olh_pkg::ZONE_W-1:0]  zone_out_reg, zone_out_next;
    olh_pkg::event_t             event_reg, event_next;
    olh_pkg::level_t             level_reg, level_next;
    logic [olh_pkg::CNT_W-1:0]   chosen_out_reg, chosen_out_next;
    logic                        from_pred_out_reg, from_pred_out_next;

    logic                      in_fire;
    logic                      out_load;
    logic                      cfg_write;
    logic                      sel_have;
    logic [olh_pkg::CNT_W-1:0] sel_chosen;
    logic                      sel_from_pred;
    logic                      in_known;
    olh_pkg::ratio_req_t       ru_req;
    olh_pkg::ratio_res_t       ru_res;
    olh_pkg::sev_dec_t         dec;

    // worst count of the incoming word
    olh_select u_select (
        .current_valid (current_valid),
        .cur_count     (cur_count),
        .median_valid  (median_valid),
        .median_count  (median_count),
        .pred_valid    (pred_valid),
        .pred_count    (pred_count),
        .have          (sel_have),
        .chosen        (sel_chosen),
        .from_pred     (sel_from_pred)
    );

    // bit-serial products and grading
    olh_ratio_unit u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ru_req),
        .res   (ru_res)
    );

    // per-zone incident state, updated when the result word of a known word is loaded
    olh_sev_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .zone   (zone_reg),
        .grade  (grade_reg),
        .below  (below_reg),
        .commit (out_load && known_reg),
        .dec    (dec)
    );

    // one word in flight; the output register lets a new word in while
    // the previous result still waits
    assign in_stall  = (state_reg != olh_pkg::TOP_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_load  = (state_reg == olh_pkg::TOP_EMIT) && (!out_valid_reg || !out_stall);
    assign in_known  = thresholds_present && (capacity != '0) && sel_have;

    // register file: release band only, low address bits ignored
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[olh_pkg::APB_ADDR_W-1:2] == olh_pkg::REG_RELEASE)
                     ? olh_pkg::APB_DATA_W'(release_reg) : '0;

    assign ru_req.start      = (state_reg == olh_pkg::TOP_START) && known_reg;
    assign ru_req.chosen     = chosen_reg;
    assign ru_req.capacity   = cap_reg;
    assign ru_req.warn       = warn_reg;
    assign ru_req.crit       = crit_reg;
    assign ru_req.release_pm = release_reg;

    always_comb
    begin
        state_next         = state_reg;
        out_valid_next     = out_valid_reg;
        release_next       = release_reg;
        zone_next          = zone_reg;
        known_next         = known_reg;
        chosen_next        = chosen_reg;
        from_pred_next     = from_pred_reg;
        cap_next           = cap_reg;
        warn_next          = warn_reg;
        crit_next          = crit_reg;
        grade_next         = grade_reg;
        below_next         = below_reg;
        zone_out_next      = zone_out_reg;
        event_next         = event_reg;
        level_next         = level_reg;
        chosen_out_next    = chosen_out_reg;
        from_pred_out_next = from_pred_out_reg;

        if (cfg_write && paddr[olh_pkg::APB_ADDR_W-1:2] == olh_pkg::REG_RELEASE)
        begin
            release_next = pwdata[olh_pkg::REL_W-1:0];
        end

        // result word leaves
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            olh_pkg::TOP_IDLE:
            begin
                if (in_fire)
                begin
                    zone_next      = zone;
                    known_next     = in_known;
                    chosen_next    = in_known ? sel_chosen : '0;
                    from_pred_next = in_known && sel_from_pred;
                    cap_next       = capacity;
                    warn_next      = warn_permille;
                    crit_next      = crit_permille;
                    state_next     = olh_pkg::TOP_START;
                end
            end
            olh_pkg::TOP_START:
            begin
                // unknown words skip the ratio unit
                state_next = known_reg ? olh_pkg::TOP_WAIT : olh_pkg::TOP_EMIT;
            end
            olh_pkg::TOP_WAIT:
            begin
                if (ru_res.done)
                begin
                    grade_next = ru_res.grade;
                    below_next = ru_res.below;
                    state_next = olh_pkg::TOP_EMIT;
                end
            end
            olh_pkg::TOP_EMIT:
            begin
                if (out_load)
                begin
                    zone_out_next      = zone_reg;
                    event_next         = known_reg ? dec.event_res : olh_pkg::EV_UNKNOWN;
                    level_next         = known_reg ? dec.level : olh_pkg::LVL_UNKNOWN;
                    chosen_out_next    = chosen_reg;
                    from_pred_out_next = from_pred_reg;
                    out_valid_next     = 1'b1;
                    state_next         = olh_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = olh_pkg::TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olh_pkg::TOP_IDLE;
            out_valid_reg <= 1'b0;
            release_reg   <= olh_pkg::RELEASE_RESET;
            known_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            release_reg   <= release_next;
            known_reg     <= known_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zone_reg          <= zone_next;
        chosen_reg        <= chosen_next;
        from_pred_reg     <= from_pred_next;
        cap_reg           <= cap_next;
        warn_reg          <= warn_next;
        crit_reg          <= crit_next;
        grade_reg         <= grade_next;
        below_reg         <= below_next;
        zone_out_reg      <= zone_out_next;
        event_reg         <= event_next;
        level_reg         <= level_next;
        chosen_out_reg    <= chosen_out_next;
        from_pred_out_reg <= from_pred_out_next;
    end

    assign out_valid       = out_valid_reg;
    assign zone_out        = zone_out_reg;
    assign event_res       = event_reg;
    assign level           = level_reg;
    assign chosen_count    = chosen_out_reg;
    assign from_prediction = from_pred_out_reg;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the per-zone occupancy alarm with hysteresis
//
// A short table of hand-picked words runs first: unknown cases, the tie rules
// of the count choice, every incident transition, the exact grade and release
// boundaries and the field extremes. Random words follow over several release
// settings. Most of them are threshold-aware sequences per zone, so incidents
// open, escalate, hold and resolve; the rest is unconstrained noise. Every
// result word is checked field by field against a typed verdict or the in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import olh_pkg::*;

    // run shape
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 280;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1000000;

    // register index past the last real register, writes there must be ignored
    localparam logic [APB_ADDR_W-3:0] REG_UNUSED = 1'b1;

    // receiver stall styles
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_PERIODIC,
        RX_HEAVY
    } stall_style_t;

    // one input word, field for field
    typedef struct {
        logic [ZONE_W-1:0]     zone;
        logic                  thr_ok;
        logic [CNT_W-1:0]      cap;
        logic [PERMILLE_W-1:0] warn;
        logic [PERMILLE_W-1:0] crit;
        logic                  cur_v;
        logic [CNT_W-1:0]      cur;
        logic                  med_v;
        logic [CNT_W-1:0]      med;
        logic                  pred_v;
        logic [CNT_W-1:0]      pred;
    } alarm_word_t;

    // one result word
    typedef struct {
        logic [ZONE_W-1:0] zone;
        event_t            ev;
        level_t            lvl;
        logic [CNT_W-1:0]  chosen;
        logic              from_pred;
    } alarm_verdict_t;

    // directed table entry, the verdict is typed in only where typed is set
    typedef struct {
        alarm_word_t    w;
        bit             typed;
        alarm_verdict_t v;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  in_valid;
    logic                  in_stall;
    logic [ZONE_W-1:0]     zone;
    logic                  thresholds_present;
    logic [CNT_W-1:0]      capacity;
    logic [PERMILLE_W-1:0] warn_permille;
    logic [PERMILLE_W-1:0] crit_permille;
    logic                  current_valid;
    logic [CNT_W-1:0]      cur_count;
    logic                  median_valid;
    logic [CNT_W-1:0]      median_count;
    logic                  pred_valid;
    logic [CNT_W-1:0]      pred_count;

    logic                  out_valid;
    logic                  out_stall;
    logic [ZONE_W-1:0]     zone_out;
    logic [EVENT_W-1:0]    event_res;
    logic [LEVEL_W-1:0]    level;
    logic [CNT_W-1:0]      chosen_count;
    logic                  from_prediction;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    sev_t             zone_sev [ZONES];    // predicted open severity per zone
    logic [REL_W-1:0] rel_pm;              // predicted release band register

    alarm_verdict_t   verdict_q [$];       // expected result words, oldest first
    dir_row_t         dir_tab [$];

    // per-zone thresholds used by the well-formed random words
    logic [CNT_W-1:0]      prof_cap  [ZONES];
    logic [PERMILLE_W-1:0] prof_warn [ZONES];
    logic [PERMILLE_W-1:0] prof_crit [ZONES];

    int fail_cnt    = 0;
    int words_sent  = 0;
    int results_cnt = 0;
    int cycle_cnt   = 0;
    int burst_left  = 1;
    int hold_ticket = 0;
    int ev_seen [8];

    always #1 clk = ~clk;

    occupancy_alarm_hysteresis u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .zone               (zone),
        .thresholds_present (thresholds_present),
        .capacity           (capacity),
        .warn_permille      (warn_permille),
        .crit_permille      (crit_permille),
        .current_valid      (current_valid),
        .cur_count          (cur_count),
        .median_valid       (median_valid),
        .median_count       (median_count),
        .pred_valid         (pred_valid),
        .pred_count         (pred_count),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .zone_out           (zone_out),
        .event_res          (event_res),
        .level              (level),
        .chosen_count       (chosen_count),
        .from_prediction    (from_prediction)
    );

    // ------------------------------------------------------------------------
    // predictor: picks the worst count, grades it and walks the zone's
    // incident state; updates zone_sev as a side effect
    // ------------------------------------------------------------------------
    function automatic alarm_verdict_t judge_zone(input alarm_word_t w);
        alarm_verdict_t v;
        logic [CNT_W-1:0] pick;
        bit               have;
        bit               by_pred;
        sev_t             grade;
        sev_t             held;
        int unsigned      idx;
        logic [63:0]      cap64;
        logic [63:0]      scaled;

        v.zone      = w.zone;
        v.ev        = EV_UNKNOWN;
        v.lvl       = LVL_UNKNOWN;
        v.chosen    = '0;
        v.from_pred = 1'b0;
        have        = 1'b0;
        by_pred     = 1'b0;
        pick        = '0;

        // unusable zone: no thresholds or zero capacity
        if (!w.thr_ok || w.cap == '0)
            return v;

        // current first, median only if strictly worse, prediction wins ties
        if (w.cur_v)
        begin
            pick = w.cur;
            have = 1'b1;
        end
        if (w.med_v && (!have || w.med > pick))
        begin
            pick = w.med;
            have = 1'b1;
        end
        if (w.pred_v && (!have || w.pred >= pick))
        begin
            pick    = w.pred;
            have    = 1'b1;
            by_pred = 1'b1;
        end
        if (!have)
            return v;

        // exact cross-multiplied ratio tests
        cap64  = 64'(w.cap);
        scaled = 64'(pick) * 64'd1000;
        if (scaled >= 64'(w.crit) * cap64)
            grade = SEV_CRIT;
        else if (scaled >= 64'(w.warn) * cap64)
            grade = SEV_WARN;
        else
            grade = SEV_NONE;

        idx         = w.zone % ZONES;
        held        = zone_sev[idx];
        v.chosen    = pick;
        v.from_pred = by_pred;

        if (held == SEV_NONE)
        begin
            if (grade == SEV_NONE)
            begin
                v.ev  = EV_QUIET;
                v.lvl = LVL_CLEAR;
            end
            else
            begin
                zone_sev[idx] = grade;
                v.ev  = EV_OPEN;
                v.lvl = (grade == SEV_CRIT) ? LVL_CRIT : LVL_WARN;
            end
        end
        else if (grade == SEV_CRIT && held == SEV_WARN)
        begin
            // escalation takes priority over release
            zone_sev[idx] = SEV_CRIT;
            v.ev  = EV_ESCALATE;
            v.lvl = LVL_CRIT;
        end
        else if (64'(pick) * 64'd1000000 < 64'(w.warn) * 64'(rel_pm) * cap64)
        begin
            zone_sev[idx] = SEV_NONE;
            v.ev  = EV_RESOLVE;
            v.lvl = LVL_CLEAR;
        end
        else
        begin
            // downgrade ignored, report the stored severity
            v.ev  = EV_HOLD;
            v.lvl = (held == SEV_CRIT) ? LVL_CRIT : LVL_WARN;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // random word generation
    // ------------------------------------------------------------------------
    function automatic void new_profiles();
        for (int z = 0; z < ZONES; z++)
        begin
            case ($urandom_range(0, 9))
                0:       prof_cap[z] = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
                1, 2:    prof_cap[z] = CNT_W'($urandom_range(201, 65535));
                default: prof_cap[z] = CNT_W'($urandom_range(1, 200));
            endcase
            if ($urandom_range(0, 7) == 0)
                prof_warn[z] = PERMILLE_W'($urandom);
            else
                prof_warn[z] = PERMILLE_W'($urandom_range(200, 1500));
            // now and then a critical ratio below the warn ratio
            if ($urandom_range(0, 6) == 0)
                prof_crit[z] = PERMILLE_W'($urandom);
            else if (int'(prof_warn[z]) + 800 > 4095)
                prof_crit[z] = '1;
            else
                prof_crit[z] = prof_warn[z] + PERMILLE_W'($urandom_range(0, 800));
        end
    endfunction

    // a count close to the base, equal a third of the time to provoke ties
    function automatic logic [CNT_W-1:0] near_count(input longint c);
        longint n;

        n = ($urandom_range(0, 2) == 0) ? c : c + $urandom_range(0, 6) - 3;
        if (n < 0)
            n = 0;
        if (n > 65535)
            n = 65535;
        return CNT_W'(n);
    endfunction

    function automatic alarm_word_t make_word();
        alarm_word_t w;
        int unsigned z;
        longint      r;
        longint      cnt;

        // noise: every field unconstrained, zero capacity a quarter of the time
        if ($urandom_range(0, 99) < 15)
        begin
            w.zone   = ZONE_W'($urandom);
            w.thr_ok = 1'($urandom_range(0, 1));
            w.cap    = ($urandom_range(0, 3) == 0) ? '0 : CNT_W'($urandom);
            w.warn   = PERMILLE_W'($urandom);
            w.crit   = PERMILLE_W'($urandom);
            w.cur_v  = 1'($urandom_range(0, 1));
            w.cur    = CNT_W'($urandom);
            w.med_v  = 1'($urandom_range(0, 1));
            w.med    = CNT_W'($urandom);
            w.pred_v = 1'($urandom_range(0, 1));
            w.pred   = CNT_W'($urandom);
            return w;
        end

        z        = $urandom_range(0, ZONES - 1);
        w.zone   = ZONE_W'(z);
        w.thr_ok = 1'b1;
        w.cap    = prof_cap[z];
        w.warn   = prof_warn[z];
        w.crit   = prof_crit[z];

        // aim the ratio at the release band, the warn or critical edge, or anywhere
        case ($urandom_range(0, 3))
            0:       r = longint'(prof_warn[z]) * longint'(rel_pm) / 1000;
            1:       r = prof_warn[z];
            2:       r = prof_crit[z];
            default: r = $urandom_range(0, 4400);
        endcase
        r   = r + $urandom_range(0, 6) - 3;
        if (r < 0)
            r = 0;
        cnt = r * longint'(prof_cap[z]) / 1000;

        w.cur    = near_count(cnt);
        w.med    = near_count(cnt);
        w.pred   = near_count(cnt);
        w.cur_v  = 1'($urandom_range(0, 1));
        w.med_v  = 1'($urandom_range(0, 1));
        w.pred_v = 1'($urandom_range(0, 1));
        if (!(w.cur_v || w.med_v || w.pred_v))
        begin
            case ($urandom_range(0, 2))
                0:       w.cur_v  = 1'b1;
                1:       w.med_v  = 1'b1;
                default: w.pred_v = 1'b1;
            endcase
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // sender side: drive one word at a falling edge, hold it until accepted,
    // then either keep valid up for the next word or open a gap
    // ------------------------------------------------------------------------
    task automatic send_word(input alarm_word_t w, input bit typed,
                             input alarm_verdict_t typed_v);
        alarm_verdict_t v;
        int             gap;

        zone               <= w.zone;
        thresholds_present <= w.thr_ok;
        capacity           <= w.cap;
        warn_permille      <= w.warn;
        crit_permille      <= w.crit;
        current_valid      <= w.cur_v;
        cur_count          <= w.cur;
        median_valid       <= w.med_v;
        median_count       <= w.med;
        pred_valid         <= w.pred_v;
        pred_count         <= w.pred;
        in_valid           <= 1'b1;

        do
            @(posedge clk);
        while (in_stall);

        // the predictor always runs so the zone state stays in step
        v = judge_zone(w);
        verdict_q.push_back(typed ? typed_v : v);
        words_sent++;

        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            // gap lengths spread over the whole processing time of a word
            case ($urandom_range(0, 9))
                0:          gap = $urandom_range(36, 80);
                1, 2, 3:    gap = $urandom_range(5, 35);
                default:    gap = $urandom_range(1, 4);
            endcase
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
        end
    endtask

    // drop valid if a burst is still running, then wait for every result
    task automatic settle_idle();
        if (in_valid)
            in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // configuration port: setup cycle, then access cycle until pready
    // ------------------------------------------------------------------------
    task automatic reg_access(input bit wr, input logic [APB_ADDR_W-3:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_release();
        logic [APB_DATA_W-1:0] rd;

        reg_access(1'b0, REG_RELEASE, '0, rd);
        if (rd[REL_W-1:0] !== rel_pm)
        begin
            $display("%0t ns: release_permille readback mismatch, expected %0d, got %0d",
                     $time, rel_pm, rd[REL_W-1:0]);
            fail_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    task automatic add_row(input int z, thr, cap, warn, crit, cv, cur, mv, med, pv, pred,
                           input bit typed, input event_t ev, input level_t lvl,
                           input int chosen, fp);
        dir_row_t row;

        row.w.zone      = ZONE_W'(z);
        row.w.thr_ok    = thr[0];
        row.w.cap       = CNT_W'(cap);
        row.w.warn      = PERMILLE_W'(warn);
        row.w.crit      = PERMILLE_W'(crit);
        row.w.cur_v     = cv[0];
        row.w.cur       = CNT_W'(cur);
        row.w.med_v     = mv[0];
        row.w.med       = CNT_W'(med);
        row.w.pred_v    = pv[0];
        row.w.pred      = CNT_W'(pred);
        row.typed       = typed;
        row.v.zone      = ZONE_W'(z);
        row.v.ev        = ev;
        row.v.lvl       = lvl;
        row.v.chosen    = CNT_W'(chosen);
        row.v.from_pred = fp[0];
        dir_tab.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : result_mon
        alarm_verdict_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t ns: result word for zone %0d with nothing expected",
                         $time, zone_out);
                fail_cnt++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("zone_out", want.zone, zone_out);
                check_field("event_res", want.ev, event_res);
                check_field("level", want.lvl, level);
                check_field("chosen_count", want.chosen, chosen_count);
                check_field("from_prediction", want.from_pred, from_prediction);
                ev_seen[want.ev]++;
                results_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver side: the stall style is picked anew at random; a request
    // from the stimulus starts a long hold-off counted here
    // ------------------------------------------------------------------------
    initial
    begin : rx_side
        stall_style_t style;
        int           span;
        int           per;
        int           duty;
        int           cyc;
        int           hold_seen;

        out_stall = 1'b0;
        style     = RX_FREE;
        span      = 0;
        per       = 4;
        duty      = 1;
        cyc       = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_seen != hold_ticket)
            begin
                hold_seen  = hold_ticket;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (span == 0)
            begin
                style = stall_style_t'($urandom_range(0, 3));
                span  = $urandom_range(20, 300);
                per   = $urandom_range(2, 9);
                duty  = $urandom_range(1, per - 1);
            end
            span--;
            case (style)
                RX_FREE:     out_stall <= 1'b0;
                RX_COIN:     out_stall <= 1'($urandom_range(0, 1));
                RX_PERIODIC: out_stall <= ((cyc % per) < duty);
                default:     out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_cnt, verdict_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [REL_W-1:0]      rel_plan [PHASES];
        logic [APB_DATA_W-1:0] junk;
        alarm_verdict_t        unused_v;

        // every input known from time zero
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_valid           = 1'b0;
        zone               = '0;
        thresholds_present = 1'b0;
        capacity           = '0;
        warn_permille      = '0;
        crit_permille      = '0;
        current_valid      = 1'b0;
        cur_count          = '0;
        median_valid       = 1'b0;
        median_count       = '0;
        pred_valid         = 1'b0;
        pred_count         = '0;
        unused_v.zone      = '0;
        unused_v.ev        = EV_UNKNOWN;
        unused_v.lvl       = LVL_UNKNOWN;
        unused_v.chosen    = '0;
        unused_v.from_pred = 1'b0;

        for (int z = 0; z < ZONES; z++)
            zone_sev[z] = SEV_NONE;
        for (int e = 0; e < 8; e++)
            ev_seen[e] = 0;
        rel_pm = RELEASE_RESET;

        // release extremes, the reset value and one random setting
        rel_plan = '{10'd0, 10'd1023, 10'd1000, 10'd0, 10'd1, 10'd900};
        rel_plan[3] = REL_W'($urandom_range(0, 1023));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value of the release band
        check_release();

        // unknown cases: no thresholds, zero capacity, no valid count
        add_row( 0, 0,   100,  800,  950, 1,    90, 0,     0, 0,     0,
                 1, EV_UNKNOWN,  LVL_UNKNOWN,     0, 0);
        add_row( 1, 1,     0,  800,  950, 1,    90, 1,    95, 1,    99,
                 1, EV_UNKNOWN,  LVL_UNKNOWN,     0, 0);
        add_row( 2, 1,   100,  800,  950, 0,    90, 0,    95, 0,    99,
                 1, EV_UNKNOWN,  LVL_UNKNOWN,     0, 0);
        // one zone through a full incident: quiet, open on the warn edge,
        // escalate by the median on the critical edge, downgrade held,
        // hold exactly on the release band, resolve just below it
        add_row( 3, 1,   100,  800,  950, 1,    50, 0,     0, 0,     0,
                 1, EV_QUIET,    LVL_CLEAR,      50, 0);
        add_row( 3, 1,   100,  800,  950, 1,    80, 0,     0, 0,     0,
                 1, EV_OPEN,     LVL_WARN,       80, 0);
        add_row( 3, 1,   100,  800,  950, 1,    94, 1,    95, 0,     0,
                 1, EV_ESCALATE, LVL_CRIT,       95, 0);
        add_row( 3, 1,   100,  800,  950, 1,    85, 0,     0, 0,     0,
                 1, EV_HOLD,     LVL_CRIT,       85, 0);
        add_row( 3, 1,   100,  800,  950, 1,    72, 0,     0, 0,     0,
                 1, EV_HOLD,     LVL_CRIT,       72, 0);
        add_row( 3, 1,   100,  800,  950, 1,    71, 0,     0, 0,     0,
                 1, EV_RESOLVE,  LVL_CLEAR,      71, 0);
        // choice rules: all equal goes to the prediction, strict median win,
        // median alone, prediction alone
        add_row( 4, 1,   100,  800,  950, 1,    60, 1,    60, 1,    60,
                 1, EV_QUIET,    LVL_CLEAR,      60, 1);
        add_row( 4, 1,   100,  800,  950, 1,    70, 1,    90, 1,    89,
                 1, EV_OPEN,     LVL_WARN,       90, 0);
        add_row( 4, 1,   100,  800,  950, 0,     0, 1,   100, 0,     0,
                 1, EV_ESCALATE, LVL_CRIT,      100, 0);
        add_row( 4, 1,   100,  800,  950, 0,     0, 0,     0, 1,     0,
                 1, EV_RESOLVE,  LVL_CLEAR,       0, 1);
        // field extremes
        add_row(15, 1, 65535, 4095, 4095, 1, 65535, 1, 65535, 1, 65535,
                 1, EV_QUIET,    LVL_CLEAR,   65535, 1);
        add_row(15, 1,     1,    0,    0, 1,     0, 0,     0, 0,     0,
                 1, EV_OPEN,     LVL_CRIT,        0, 0);
        add_row(15, 1,     1,    0,    0, 1,     0, 0,     0, 0,     0,
                 1, EV_HOLD,     LVL_CRIT,        0, 0);
        add_row(15, 1, 65535, 4095, 4095, 1,     0, 0,     0, 0,     0,
                 1, EV_RESOLVE,  LVL_CLEAR,       0, 0);
        // unit capacity, and an unknown word that must leave the state alone
        add_row( 5, 1,     1, 1000, 2000, 0,     0, 0,     0, 1,     1,
                 1, EV_OPEN,     LVL_WARN,        1, 1);
        add_row( 5, 1,     1, 1000, 2000, 1,     2, 0,     0, 0,     0,
                 1, EV_ESCALATE, LVL_CRIT,        2, 0);
        add_row( 5, 0,     1, 1000, 2000, 1,     2, 0,     0, 0,     0,
                 1, EV_UNKNOWN,  LVL_UNKNOWN,     0, 0);
        add_row( 5, 1,     1, 1000, 2000, 1,     1, 0,     0, 0,     0,
                 1, EV_HOLD,     LVL_CRIT,        1, 0);
        // warn incident held on the band edge, then released
        add_row( 6, 1,  1000,  500,  900, 1,   600, 0,     0, 1,   599,
                 1, EV_OPEN,     LVL_WARN,      600, 0);
        add_row( 6, 1,  1000,  500,  900, 0,     0, 1,   450, 0,     0,
                 1, EV_HOLD,     LVL_WARN,      450, 0);
        add_row( 6, 1,  1000,  500,  900, 1,   449, 0,     0, 0,     0,
                 1, EV_RESOLVE,  LVL_CLEAR,     449, 0);
        // critical ratio below warn, then a large median, both left to the predictor
        add_row( 7, 1, 12345, 3000, 1500, 1, 20000, 1, 19000, 1, 20001,
                 0, EV_UNKNOWN,  LVL_UNKNOWN,     0, 0);
        add_row(10, 1, 40000, 2500, 4000, 0,     0, 1, 65535, 1,     0,
                 0, EV_UNKNOWN,  LVL_UNKNOWN,     0, 0);

        foreach (dir_tab[i])
            send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].v);

        // random phases, one release setting each
        for (int p = 0; p < PHASES; p++)
        begin
            settle_idle();
            // upper data bits carry junk, only the low bits are kept
            junk = $urandom;
            reg_access(1'b1, REG_RELEASE, {junk[APB_DATA_W-1:REL_W], rel_plan[p]}, junk);
            rel_pm = rel_plan[p];
            check_release();
            if (p == 3)
            begin
                // a write past the register map must not disturb anything
                reg_access(1'b1, REG_UNUSED, $urandom, junk);
                check_release();
            end
            new_profiles();
            // long output hold-off while words keep coming
            if (p == 1 || p == 4)
                hold_ticket++;
            repeat (PHASE_WORDS)
                send_word(make_word(), 1'b0, unused_v);
        end

        settle_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d words, %0d directed, %0d release settings, %0d hold-offs",
                 words_sent, dir_tab.size(), PHASES + 1, hold_ticket);
        $display("checked %0d: unknown %0d quiet %0d open %0d esc %0d resolve %0d hold %0d",
                 results_cnt, ev_seen[EV_UNKNOWN], ev_seen[EV_QUIET], ev_seen[EV_OPEN],
                 ev_seen[EV_ESCALATE], ev_seen[EV_RESOLVE], ev_seen[EV_HOLD]);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ occupancy_alarm_hysteresis.f @@
rtl/core/olh_pkg.sv
rtl/core/olh_select.sv
rtl/core/olh_ratio_unit.sv
rtl/core/olh_sev_store.sv
rtl/core/occupancy_alarm_hysteresis.sv
bench/tb_top.sv
